// ===== hdl/irdu_pkg.sv =====
`timescale 1ns / 1ps

package irdu_pkg;

    localparam int LENGTH_BITS_DEFAULT = 16;
    localparam int MSG_LEN_BITS = 17;
    localparam int REV_BITS = 64;
    localparam int OUT_LEN_BITS = 16;
    localparam int FIFO_DEPTH = 4;

    localparam logic [2:0] STATUS_NONE          = 3'd0;
    localparam logic [2:0] STATUS_TOO_LARGE     = 3'd1;
    localparam logic [2:0] STATUS_MALFORMED     = 3'd2;
    localparam logic [2:0] STATUS_VERSION       = 3'd3;
    localparam logic [2:0] STATUS_COMMAND       = 3'd4;
    localparam logic [2:0] STATUS_PAYLOAD_LARGE = 3'd5;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [7:0] CFG_MAX_MESSAGE = 8'd0;
    localparam logic [7:0] CFG_MAX_PAYLOAD = 8'd1;

    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef struct packed {
        logic                    kind;
        logic [7:0]              payload_byte;
        logic [2:0]              status;
        logic [REV_BITS-1:0]     revision;
        logic [OUT_LEN_BITS-1:0] payload_length;
        logic                    final_item;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic [7:0] version_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0: c = 8'h53;
            2'd1: c = 8'h53;
            2'd2: c = 8'h47;
            default: c = 8'h31;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] command_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0: c = 8'h49;
            3'd1: c = 8'h4e;
            3'd2: c = 8'h53;
            3'd3: c = 8'h45;
            3'd4: c = 8'h52;
            3'd5: c = 8'h54;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // bit 4 set marks a character that is not hex
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] n;
        if (c >= 8'h30 && c <= 8'h39)
            n = {1'b0, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            n = {1'b0, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            n = {1'b0, 4'(c - 8'h37)};
        else
            n = 5'h10;
        return n;
    endfunction

endpackage

// ===== hdl/irdu_out_fifo.sv =====
`timescale 1ns / 1ps

module irdu_out_fifo
(
    input  logic             clk,
    input  logic             rst_n,
    input  irdu_pkg::push_t  push,
    output logic             space,
    output logic             out_valid,
    input  logic             out_ready,
    output irdu_pkg::result_t out_item
);

    irdu_pkg::result_t mem [irdu_pkg::FIFO_DEPTH];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       pop;

    assign pop = out_valid && out_ready;
    assign out_valid = count_reg != 3'd0;
    assign out_item = mem[rd_ptr_reg];
    assign space = count_reg <= 3'd2;
    assign count_next = count_reg + {1'b0, push.count} - {2'b00, pop};

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem[wr_ptr_reg + 2'd1] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + push.count;
            rd_ptr_reg <= rd_ptr_reg + {1'b0, pop};
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/insert_request_decoder_unit.sv =====
`timescale 1ns / 1ps

// Insert request decoder. Takes one message byte per transfer and checks that the
// message reads "<version> INSERT <decimal revision> <hex payload>", emitting each
// decoded payload byte at once (tuser 0) and a status item closing every message
// (tuser 1, tlast 1) carrying status, revision and saturating payload length.
// One byte is taken per clock cycle; all parsing is a single combinational pass into
// the message state registers, and results go into a four-entry output queue, so
// the input stalls only while that queue holds three or more results.
// Configuration registers: index 0 longest accepted message in bytes, index 1
// largest accepted decoded payload in bytes; write them only while no message is
// in flight.

module insert_request_decoder_unit
#(
    parameter int LENGTH_BITS = irdu_pkg::LENGTH_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] message_byte
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // [7:0] payload_byte, [10:8] status,
                                        // [74:11] revision, [90:75] payload_length
    output logic        m_axis_tuser,   // result_kind
    output logic        m_axis_tlast,   // final_item
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int RB = irdu_pkg::REV_BITS;
    localparam int MB = irdu_pkg::MSG_LEN_BITS;

    logic [15:0] max_msg_reg;
    logic [14:0] max_pay_reg;

    logic [MB-1:0]          msg_len_reg,   msg_len_next;
    logic [2:0]             field_reg,     field_next;
    logic [3:0]             pos_reg,       pos_next;
    logic                   ver_ok_reg,    ver_ok_next;
    logic                   cmd_ok_reg,    cmd_ok_next;
    logic [RB-1:0]          rev_reg,       rev_next;
    logic                   rev_bad_reg,   rev_bad_next;
    logic [3:0]             hi_reg,        hi_next;
    logic                   odd_reg,       odd_next;
    logic                   hex_bad_reg,   hex_bad_next;
    logic [LENGTH_BITS-1:0] pcount_reg,    pcount_next;
    logic [1:0]             u_rem_reg,     u_rem_next;
    logic [2:0]             u_len_reg,     u_len_next;
    logic [20:0]            u_val_reg,     u_val_next;
    logic                   u_bad_reg,     u_bad_next;

    irdu_pkg::push_t   push;
    irdu_pkg::result_t out_item;
    logic              space;
    logic              accept;

    logic [7:0]    c;
    logic [4:0]    nib;
    logic [7:0]    dbyte;
    logic          emit;
    logic [RB+3:0] rev_wide;
    logic [2:0]    st;
    irdu_pkg::result_t byte_item, stat_item;

    assign s_axis_tready = space;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;
    assign c = s_axis_tdata;

    always_comb
    begin
        msg_len_next = msg_len_reg;
        field_next   = field_reg;
        pos_next     = pos_reg;
        ver_ok_next  = ver_ok_reg;
        cmd_ok_next  = cmd_ok_reg;
        rev_next     = rev_reg;
        rev_bad_next = rev_bad_reg;
        hi_next      = hi_reg;
        odd_next     = odd_reg;
        hex_bad_next = hex_bad_reg;
        pcount_next  = pcount_reg;
        u_rem_next   = u_rem_reg;
        u_len_next   = u_len_reg;
        u_val_next   = u_val_reg;
        u_bad_next   = u_bad_reg;
        emit  = 1'b0;
        nib   = irdu_pkg::hex_nibble(c);
        dbyte = {hi_reg, nib[3:0]};
        rev_wide = {1'b0, rev_reg, 3'd0} + {3'd0, rev_reg, 1'b0}
                   + {{RB{1'b0}}, 4'(c - 8'h30)};

        if (msg_len_reg != {MB{1'b1}})
            msg_len_next = msg_len_reg + 1'b1;

        if (c == irdu_pkg::CHAR_SPACE)
        begin
            if (field_reg == 3'd0 && pos_reg != 4'd4) ver_ok_next = 1'b0;
            if (field_reg == 3'd1 && pos_reg != 4'd6) cmd_ok_next = 1'b0;
            if (field_reg == 3'd2 && pos_reg == 4'd0) rev_bad_next = 1'b1;
            if (field_reg == 3'd3 && odd_reg) hex_bad_next = 1'b1;
            if (field_reg != 3'd7) field_next = field_reg + 3'd1;
            pos_next = 4'd0;
        end
        else
        begin
            case (field_reg)
                3'd0:
                begin
                    if (pos_reg >= 4'd4 || irdu_pkg::version_char(pos_reg[1:0]) != c)
                        ver_ok_next = 1'b0;
                end
                3'd1:
                begin
                    if (pos_reg >= 4'd6 || irdu_pkg::command_char(pos_reg[2:0]) != c)
                        cmd_ok_next = 1'b0;
                end
                3'd2:
                begin
                    if (c >= 8'h30 && c <= 8'h39)
                    begin
                        if (rev_wide[RB+3:RB] != 4'd0) rev_bad_next = 1'b1;
                        else rev_next = rev_wide[RB-1:0];
                    end
                    else
                        rev_bad_next = 1'b1;
                end
                3'd3:
                begin
                    if (nib[4]) hex_bad_next = 1'b1;
                    if (!odd_reg)
                    begin
                        hi_next  = nib[4] ? 4'd0 : nib[3:0];
                        odd_next = 1'b1;
                    end
                    else
                    begin
                        odd_next = 1'b0;
                        if (!hex_bad_next)
                        begin
                            emit = 1'b1;
                            if (pcount_reg != {LENGTH_BITS{1'b1}})
                                pcount_next = pcount_reg + 1'b1;
                            if (!u_bad_reg)
                            begin
                                if (u_rem_reg == 2'd0)
                                begin
                                    if (dbyte == 8'h00)
                                        u_bad_next = 1'b1;
                                    else if (dbyte <= 8'h7f)
                                        u_bad_next = 1'b0;
                                    else if (dbyte >= 8'hc2 && dbyte <= 8'hdf)
                                    begin
                                        u_len_next = 3'd2; u_rem_next = 2'd1;
                                        u_val_next = {16'd0, dbyte[4:0]};
                                    end
                                    else if (dbyte >= 8'he0 && dbyte <= 8'hef)
                                    begin
                                        u_len_next = 3'd3; u_rem_next = 2'd2;
                                        u_val_next = {17'd0, dbyte[3:0]};
                                    end
                                    else if (dbyte >= 8'hf0 && dbyte <= 8'hf4)
                                    begin
                                        u_len_next = 3'd4; u_rem_next = 2'd3;
                                        u_val_next = {18'd0, dbyte[2:0]};
                                    end
                                    else
                                        u_bad_next = 1'b1;
                                end
                                else if (dbyte[7:6] != 2'b10)
                                begin
                                    u_bad_next = 1'b1;
                                    u_rem_next = 2'd0;
                                end
                                else
                                begin
                                    u_val_next = {u_val_reg[14:0], dbyte[5:0]};
                                    u_rem_next = u_rem_reg - 2'd1;
                                    if (u_rem_next == 2'd0)
                                    begin
                                        if ((u_len_reg == 3'd3 && u_val_next < 21'h800) ||
                                            (u_len_reg == 3'd4 && u_val_next < 21'h10000) ||
                                            (u_val_next >= 21'hd800 &&
                                             u_val_next <= 21'hdfff) ||
                                            u_val_next > 21'h10ffff)
                                            u_bad_next = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
            if (pos_reg != 4'd15) pos_next = pos_reg + 4'd1;
        end

        if (s_axis_tlast)
        begin
            if (field_next == 3'd0 && pos_next != 4'd4) ver_ok_next = 1'b0;
            if (field_next == 3'd1 && pos_next != 4'd6) cmd_ok_next = 1'b0;
            if (field_next == 3'd2 && pos_next == 4'd0) rev_bad_next = 1'b1;
            if (field_next == 3'd3 && odd_next) hex_bad_next = 1'b1;
        end

        if (msg_len_next > MB'(max_msg_reg))
            st = irdu_pkg::STATUS_TOO_LARGE;
        else if (field_next != 3'd3)
            st = irdu_pkg::STATUS_MALFORMED;
        else if (!ver_ok_next)
            st = irdu_pkg::STATUS_VERSION;
        else if (!cmd_ok_next)
            st = irdu_pkg::STATUS_COMMAND;
        else if (rev_bad_next || rev_next == '0)
            st = irdu_pkg::STATUS_MALFORMED;
        else if (hex_bad_next)
            st = irdu_pkg::STATUS_MALFORMED;
        else if (33'(pcount_next) > 33'(max_pay_reg))
            st = irdu_pkg::STATUS_PAYLOAD_LARGE;
        else if (u_bad_next || u_rem_next != 2'd0)
            st = irdu_pkg::STATUS_MALFORMED;
        else
            st = irdu_pkg::STATUS_NONE;

        byte_item = '0;
        byte_item.kind = irdu_pkg::KIND_BYTE;
        byte_item.payload_byte = dbyte;

        stat_item = '0;
        stat_item.kind = irdu_pkg::KIND_STATUS;
        stat_item.status = st;
        stat_item.revision = (st == irdu_pkg::STATUS_NONE) ? rev_next : '0;
        stat_item.payload_length = irdu_pkg::OUT_LEN_BITS'(pcount_next);
        stat_item.final_item = 1'b1;

        push.first  = emit ? byte_item : stat_item;
        push.second = stat_item;
        if (!accept)
            push.count = 2'd0;
        else
            push.count = {1'b0, emit} + {1'b0, s_axis_tlast};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_msg_reg <= 16'hffff;
            max_pay_reg <= 15'h7fff;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == irdu_pkg::CFG_MAX_MESSAGE)
                max_msg_reg <= cfg_data;
            else if (cfg_index == irdu_pkg::CFG_MAX_PAYLOAD)
                max_pay_reg <= cfg_data[14:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_len_reg <= '0;
            field_reg   <= '0;
            pos_reg     <= '0;
            ver_ok_reg  <= 1'b1;
            cmd_ok_reg  <= 1'b1;
            rev_reg     <= '0;
            rev_bad_reg <= 1'b0;
            hi_reg      <= '0;
            odd_reg     <= 1'b0;
            hex_bad_reg <= 1'b0;
            pcount_reg  <= '0;
            u_rem_reg   <= '0;
            u_len_reg   <= '0;
            u_val_reg   <= '0;
            u_bad_reg   <= 1'b0;
        end
        else if (accept && s_axis_tlast)
        begin
            msg_len_reg <= '0;
            field_reg   <= '0;
            pos_reg     <= '0;
            ver_ok_reg  <= 1'b1;
            cmd_ok_reg  <= 1'b1;
            rev_reg     <= '0;
            rev_bad_reg <= 1'b0;
            hi_reg      <= '0;
            odd_reg     <= 1'b0;
            hex_bad_reg <= 1'b0;
            pcount_reg  <= '0;
            u_rem_reg   <= '0;
            u_len_reg   <= '0;
            u_val_reg   <= '0;
            u_bad_reg   <= 1'b0;
        end
        else if (accept)
        begin
            msg_len_reg <= msg_len_next;
            field_reg   <= field_next;
            pos_reg     <= pos_next;
            ver_ok_reg  <= ver_ok_next;
            cmd_ok_reg  <= cmd_ok_next;
            rev_reg     <= rev_next;
            rev_bad_reg <= rev_bad_next;
            hi_reg      <= hi_next;
            odd_reg     <= odd_next;
            hex_bad_reg <= hex_bad_next;
            pcount_reg  <= pcount_next;
            u_rem_reg   <= u_rem_next;
            u_len_reg   <= u_len_next;
            u_val_reg   <= u_val_next;
            u_bad_reg   <= u_bad_next;
        end
    end

    irdu_out_fifo u_out_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space     (space),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (out_item)
    );

    assign m_axis_tuser = out_item.kind;
    assign m_axis_tlast = out_item.final_item;
    assign m_axis_tdata = {5'd0, out_item.payload_length, out_item.revision,
                           out_item.status, out_item.payload_byte};

endmodule

// ===== hdl/irdu_checker.sv =====
`timescale 1ns / 1ps

module irdu_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output dropped while stalled");

    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tlast == m_axis_tuser)
        else $error("tlast differs from kind");

    a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[95:8] == '0)
        else $error("payload item carries status fields");

    a_rev_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser && m_axis_tdata[10:8] != 3'd0
        |-> m_axis_tdata[74:11] == '0 && m_axis_tdata[7:0] == '0)
        else $error("failed status carries revision");

endmodule

bind insert_request_decoder_unit irdu_checker u_irdu_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/tb_checker.sv =====
`timescale 1ns / 1ps

module tb_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [95:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    input  logic        m_axis_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output int          status_seen,
    output int          byte_seen
);

    logic [15:0] lim_msg;
    logic [14:0] lim_pay;
    logic [16:0] msg_len;
    logic [2:0]  fld;
    logic [3:0]  pos;
    logic        ver_ok;
    logic        cmd_ok;
    logic [63:0] rev;
    logic        rev_bad;
    logic [3:0]  hi_nib;
    logic        odd;
    logic        hex_bad;
    logic [15:0] pay_cnt;
    logic [1:0]  u_rem;
    logic [2:0]  u_len;
    logic [20:0] u_val;
    logic        u_bad;

    irdu_pkg::result_t expected_q[$];

    function automatic logic [7:0] ver_char(int p);
        case (p)
            0, 1: return 8'h53;
            2: return 8'h47;
            default: return 8'h31;
        endcase
    endfunction

    function automatic logic [7:0] cmd_char(int p);
        case (p)
            0: return 8'h49;
            1: return 8'h4e;
            2: return 8'h53;
            3: return 8'h45;
            4: return 8'h52;
            default: return 8'h54;
        endcase
    endfunction

    task automatic clear_msg();
        msg_len = 0; fld = 0; pos = 0; ver_ok = 1; cmd_ok = 1; rev = 0; rev_bad = 0;
        hi_nib = 0; odd = 0; hex_bad = 0; pay_cnt = 0; u_rem = 0; u_len = 0;
        u_val = 0; u_bad = 0;
    endtask

    task automatic close_fld();
        if (fld == 0 && pos != 4) ver_ok = 0;
        if (fld == 1 && pos != 6) cmd_ok = 0;
        if (fld == 2 && pos == 0) rev_bad = 1;
        if (fld == 3 && odd) hex_bad = 1;
    endtask

    task automatic check_utf8(logic [7:0] b);
        if (u_bad)
            return;
        if (u_rem == 0)
        begin
            if (b == 0) u_bad = 1;
            else if (b <= 8'h7f) ;
            else if (b >= 8'hc2 && b <= 8'hdf)
            begin
                u_len = 2; u_rem = 1; u_val = b & 8'h1f;
            end
            else if (b >= 8'he0 && b <= 8'hef)
            begin
                u_len = 3; u_rem = 2; u_val = b & 8'h0f;
            end
            else if (b >= 8'hf0 && b <= 8'hf4)
            begin
                u_len = 4; u_rem = 3; u_val = b & 8'h07;
            end
            else u_bad = 1;
            return;
        end
        if (b[7:6] != 2'b10)
        begin
            u_bad = 1; u_rem = 0;
            return;
        end
        u_val = {u_val[14:0], b[5:0]};
        u_rem = u_rem - 1;
        if (u_rem == 0)
            if ((u_len == 3 && u_val < 21'h800) || (u_len == 4 && u_val < 21'h10000)
                || (u_val >= 21'hd800 && u_val <= 21'hdfff) || u_val > 21'h10ffff)
                u_bad = 1;
    endtask

    function automatic int hexval(logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    task automatic decode_byte(logic [7:0] c, logic last);
        irdu_pkg::result_t r;
        int n;
        logic [63:0] d;
        logic [2:0] st;
        if (msg_len != 17'h1ffff) msg_len++;
        if (c == irdu_pkg::CHAR_SPACE)
        begin
            close_fld();
            if (fld != 7) fld++;
            pos = 0;
        end
        else
        begin
            if (fld == 0)
            begin
                if (pos >= 4 || ver_char(pos) != c) ver_ok = 0;
            end
            else if (fld == 1)
            begin
                if (pos >= 6 || cmd_char(pos) != c) cmd_ok = 0;
            end
            else if (fld == 2)
            begin
                if (c >= "0" && c <= "9")
                begin
                    d = c - "0";
                    if (rev > (64'hffff_ffff_ffff_ffff - d) / 10) rev_bad = 1;
                    else rev = rev * 10 + d;
                end
                else rev_bad = 1;
            end
            else if (fld == 3)
            begin
                n = hexval(c);
                if (n < 0) hex_bad = 1;
                if (!odd)
                begin
                    hi_nib = (n < 0) ? 4'd0 : n[3:0];
                    odd = 1;
                end
                else
                begin
                    odd = 0;
                    if (!hex_bad)
                    begin
                        r = '0;
                        r.kind = irdu_pkg::KIND_BYTE;
                        r.payload_byte = {hi_nib, n[3:0]};
                        if (pay_cnt != 16'hffff) pay_cnt++;
                        check_utf8(r.payload_byte);
                        expected_q.insert(expected_q.size(), r);
                    end
                end
            end
            if (pos != 15) pos++;
        end
        if (last)
        begin
            close_fld();
            if (msg_len > lim_msg) st = irdu_pkg::STATUS_TOO_LARGE;
            else if (fld != 3) st = irdu_pkg::STATUS_MALFORMED;
            else if (!ver_ok) st = irdu_pkg::STATUS_VERSION;
            else if (!cmd_ok) st = irdu_pkg::STATUS_COMMAND;
            else if (rev_bad || rev == 0 || hex_bad) st = irdu_pkg::STATUS_MALFORMED;
            else if (pay_cnt > lim_pay) st = irdu_pkg::STATUS_PAYLOAD_LARGE;
            else if (u_bad || u_rem != 0) st = irdu_pkg::STATUS_MALFORMED;
            else st = irdu_pkg::STATUS_NONE;
            r = '0;
            r.kind = irdu_pkg::KIND_STATUS;
            r.status = st;
            r.revision = (st == irdu_pkg::STATUS_NONE) ? rev : 64'd0;
            r.payload_length = pay_cnt;
            r.final_item = 1;
            expected_q.insert(expected_q.size(), r);
            clear_msg();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        irdu_pkg::result_t got;
        irdu_pkg::result_t exp_r;
        if (!rst_n)
        begin
            lim_msg = 16'hffff;
            lim_pay = 15'h7fff;
            clear_msg();
            expected_q.delete();
            fail_count = 0;
            status_seen = 0;
            byte_seen = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == irdu_pkg::CFG_MAX_MESSAGE) lim_msg = cfg_data;
                else if (cfg_index == irdu_pkg::CFG_MAX_PAYLOAD) lim_pay = cfg_data[14:0];
            end
            if (s_axis_tvalid && s_axis_tready)
                decode_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.kind = m_axis_tuser;
                got.payload_byte = m_axis_tdata[7:0];
                got.status = m_axis_tdata[10:8];
                got.revision = m_axis_tdata[74:11];
                got.payload_length = m_axis_tdata[90:75];
                got.final_item = m_axis_tlast;
                if (got.kind == irdu_pkg::KIND_STATUS) status_seen++;
                else byte_seen++;
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected transfer: %p", got);
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (got !== exp_r)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("expected %p\n  actual %p", exp_r, got);
                    end
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 0;
    logic        s_axis_tlast = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [95:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = 0;
    logic [15:0] cfg_data = 0;
    int          fail_count;
    int          pending;
    int          status_seen;
    int          byte_seen;
    int          sent;
    int          msgs;
    bit          quiet;
    bit          hold_long;
    string       ver_text;
    string       bad_ver_text;

    byte unsigned msg_buf[$];

    always #2 clk = ~clk;

    insert_request_decoder_unit DUT (.*);

    tb_checker checker_i (.*);

    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 15);
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= b;
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sent++;
    endtask

    task automatic send_msg();
        for (int i = 0; i < msg_buf.size(); i++)
            send_byte(msg_buf[i], i == msg_buf.size() - 1);
        msgs++;
        msg_buf.delete();
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            msg_buf.insert(msg_buf.size(), s[i]);
    endtask

    task automatic push_hex(byte unsigned b);
        string h;
        h = $urandom_range(0, 1) ? $sformatf("%02x", b) : $sformatf("%02X", b);
        push_text(h);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [15:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic push_utf8_char();
        int k;
        int cp;
        k = $urandom_range(0, 3);
        case (k)
            0: push_hex(8'($urandom_range(1, 127)));
            1:
            begin
                cp = $urandom_range(16'h80, 16'h7ff);
                push_hex(8'(8'hc0 | (cp >> 6))); push_hex(8'(8'h80 | (cp & 63)));
            end
            2:
            begin
                cp = $urandom_range(16'h800, 16'hffff);
                if (cp >= 16'hd800 && cp <= 16'hdfff) cp = 16'he000;
                push_hex(8'(8'he0 | (cp >> 12))); push_hex(8'(8'h80 | ((cp >> 6) & 63)));
                push_hex(8'(8'h80 | (cp & 63)));
            end
            default:
            begin
                cp = $urandom_range(32'h10000, 32'h10ffff);
                push_hex(8'(8'hf0 | (cp >> 18))); push_hex(8'(8'h80 | ((cp >> 12) & 63)));
                push_hex(8'(8'h80 | ((cp >> 6) & 63))); push_hex(8'(8'h80 | (cp & 63)));
            end
        endcase
    endtask

    task automatic rand_revision();
        int n;
        n = $urandom_range(0, 9);
        if (n == 9)
            push_text($urandom_range(0, 1) ? "18446744073709551615" : "18446744073709551616");
        else
            for (int i = 0; i <= n; i++)
                msg_buf.insert(msg_buf.size(), 8'("0" + $urandom_range(0, 9)));
    endtask

    task automatic rand_message();
        int kind;
        int n;
        kind = $urandom_range(0, 19);
        if (kind < 12)
        begin
            push_text({ver_text, " INSERT "});
            rand_revision();
            msg_buf.insert(msg_buf.size(), 8'h20);
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++) push_utf8_char();
        end
        else if (kind < 16)
        begin
            push_text({ver_text, " INSERT "});
            rand_revision();
            msg_buf.insert(msg_buf.size(), 8'h20);
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) push_hex(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 3) == 0)
                msg_buf.insert(msg_buf.size(), 8'("0" + $urandom_range(0, 9)));
            if ($urandom_range(0, 3) == 0)
                msg_buf.insert($urandom_range(0, msg_buf.size()), 8'($urandom_range(0, 255)));
        end
        else
        begin
            n = $urandom_range(1, 16);
            for (int i = 0; i < n; i++)
                msg_buf.insert(msg_buf.size(),
                               $urandom_range(0, 3) == 0 ? 8'h20 : 8'($urandom_range(0, 255)));
        end
        send_msg();
    endtask

    initial
    begin
        #400000;
        $display("insert_request_decoder_unit: mismatch");
        $finish;
    end

    initial
    begin
        forever
        begin
            if (hold_long)
            begin
                m_axis_tready <= 0;
                repeat (300) @(posedge clk);
                hold_long = 0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        sent = 0;
        msgs = 0;
        quiet = 0;
        hold_long = 0;
        ver_text = $sformatf("%c%c%c%c", 8'h53, 8'h53, 8'h47, 8'h31);
        bad_ver_text = $sformatf("%c%c%c%c", 8'h53, 8'h53, 8'h47, 8'h32);
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        push_text({ver_text, " INSERT 1 "}); push_hex(8'h41); push_hex(8'h7f); send_msg();
        push_text({ver_text, " INSERT 18446744073709551615 c3a9"}); send_msg();
        push_text({ver_text, " INSERT 18446744073709551616 41"}); send_msg();
        push_text({ver_text, " INSERT 000 41"}); send_msg();
        push_text({ver_text, " INSERT 7 00"}); send_msg();
        push_text({ver_text, " INSERT 7 c0af"}); send_msg();
        push_text({ver_text, " INSERT 7 eda080"}); send_msg();
        push_text({ver_text, " INSERT 7 f4908080"}); send_msg();
        push_text({ver_text, " INSERT 7 4g41"}); send_msg();
        push_text({ver_text, " INSERT 7 414"}); send_msg();
        push_text({ver_text, " INSERT 7 c3"}); send_msg();
        push_text({bad_ver_text, " INSERT 7 41"}); send_msg();
        push_text({ver_text, " INSERT  41"}); send_msg();
        push_text({ver_text, " DELETE 7 41"}); send_msg();
        push_text({ver_text, " INSERT 7 41 42"}); send_msg();
        push_text({ver_text, " INSERT 7"}); send_msg();
        msg_buf.insert(msg_buf.size(), 8'hff); send_msg();
        push_text({ver_text, " INSERT 9 "}); send_msg();
        drain();

        write_reg(irdu_pkg::CFG_MAX_MESSAGE, 16'd0);
        write_reg(irdu_pkg::CFG_MAX_PAYLOAD, 16'hffff);
        push_text({ver_text, " INSERT 5 41"}); send_msg();
        drain();
        write_reg(irdu_pkg::CFG_MAX_MESSAGE, 16'd16);
        write_reg(irdu_pkg::CFG_MAX_PAYLOAD, 16'd0);
        push_text({ver_text, " INSERT 5 41"}); send_msg();
        push_text({ver_text, " INSERT 5 4142"}); send_msg();
        drain();
        write_reg(irdu_pkg::CFG_MAX_MESSAGE, 16'd24);
        write_reg(irdu_pkg::CFG_MAX_PAYLOAD, 16'd2);
        write_reg(8'd7, 16'd1);
        repeat (16) rand_message();
        drain();

        write_reg(irdu_pkg::CFG_MAX_MESSAGE, 16'hffff);
        write_reg(irdu_pkg::CFG_MAX_PAYLOAD, 16'h7fff);
        hold_long = 1;
        repeat (6) rand_message();
        drain();
        while (sent < 900) rand_message();
        quiet = 1;
        while (sent < 1050) rand_message();
        s_axis_tvalid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("sent %0d bytes in %0d messages; got %0d payload bytes, %0d status items",
                 sent, msgs, byte_seen, status_seen);
        if (fail_count == 0)
            $display("insert_request_decoder_unit: match");
        else
            $display("insert_request_decoder_unit: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/irdu_pkg.sv
hdl/irdu_out_fifo.sv
hdl/insert_request_decoder_unit.sv
hdl/irdu_checker.sv
tb/tb_checker.sv
tb/tb_top.sv
